### hdl/wtsp_pkg.sv
package wtsp_pkg;

  // Coordinate and camera-space widths
  localparam int CoordW = 32;
  localparam int RelW   = CoordW + 1;
  localparam int MatW   = 20;
  localparam int MatSh  = 10;
  localparam int ProdW  = RelW + MatW;
  localparam int TermW  = ProdW - MatSh;
  localparam int SumW   = TermW + 2;
  localparam int MagW   = SumW - 1;

  // Dividers: q = min(floor(n * 2^DivSh / d), 2^(DivQW-1)).
  // The ratio divider gives r = |n| / |z| in Q.24; any r at the cap already
  // saturates t. The scale divider reuses the same 24-bit shift, so t drops
  // the TSh extra fraction bits of its quotient.
  localparam int ScaleW     = 24;
  localparam int CtrW       = 16;
  localparam int DivNW      = 55;
  localparam int DivDW      = MagW;
  localparam int DivSh      = 24;
  localparam int DivQW      = DivNW;
  localparam int DivLoW     = DivQW - DivSh;
  localparam int DivLat     = DivQW + 1;
  localparam int DivPipeLat = 2 * DivLat;
  localparam logic [DivQW-1:0] DivCap = {1'b1, {(DivQW - 1){1'b0}}};
  localparam int TSh        = 8;
  localparam int QW         = DivQW - TSh;

  // Final scaling
  localparam int FW    = QW + 1;
  localparam int FLoW  = 24;
  localparam int FHiW  = FW - FLoW;
  localparam int PLoW  = CtrW + FLoW;
  localparam int PHiW  = CtrW + 1 + FHiW;
  localparam int FullW = PHiW + FLoW;
  localparam int OutSh = 12;
  localparam int OutW  = 32;
  localparam logic signed [FW-1:0] OneQ24 = FW'(1) << 24;
  localparam logic signed [SumW-1:0] NearZ = SumW'(6554);

  // Configuration port
  localparam int CfgW   = 60;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegCamPosX    = 3'd0,
    RegCamPosY    = 3'd1,
    RegCamPosZ    = 3'd2,
    RegRowAside   = 3'd3,
    RegRowUp      = 3'd4,
    RegRowForward = 3'd5,
    RegProjScales = 3'd6,
    RegScreenCtr  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic in_front;
    logic div_zero;
  } side_t;

endpackage

### hdl/wtsp_div.sv
module wtsp_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [wtsp_pkg::DivNW-1:0]    num_i,
  input  logic [wtsp_pkg::DivDW-1:0]    den_i,
  output logic [wtsp_pkg::DivQW-1:0]    quo_o
);

  localparam int NW  = wtsp_pkg::DivNW;
  localparam int DW  = wtsp_pkg::DivDW;
  localparam int QN  = wtsp_pkg::DivQW;
  localparam int LW  = wtsp_pkg::DivLoW;
  localparam int HiW = NW - LW;

  logic [DW-1:0] rem_q [QN];
  logic [DW-1:0] den_q [QN];
  logic [LW-1:0] lo_q  [QN];
  logic [QN-1:0] quo_q [QN+1];
  logic          ovf_q [QN+1];
  logic [DW:0]   trial [QN];
  logic [DW:0]   diff  [QN];
  logic          ge    [QN];
  logic [DW-1:0] hi_ext;

  assign hi_ext = {{(DW - HiW){1'b0}}, num_i[NW-1:LW]};

  // Trial subtract for every stage, next numerator bit at the top of lo
  always_comb begin
    for (int s = 0; s < QN; s++) begin
      trial[s] = {rem_q[s], lo_q[s][LW-1]};
      diff[s]  = trial[s] - {1'b0, den_q[s]};
      ge[s]    = (trial[s] >= {1'b0, den_q[s]});
    end
  end

  // Load the high numerator part, flag a quotient past the cap range,
  // then one restoring step per stage, most significant quotient bit first
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi_ext;
      ovf_q[0] <= (hi_ext >= den_i);
      den_q[0] <= den_i;
      lo_q[0]  <= num_i[LW-1:0];
      quo_q[0] <= '0;
      for (int s = 1; s < QN; s++) begin
        rem_q[s] <= ge[s-1] ? diff[s-1][DW-1:0] : trial[s-1][DW-1:0];
        den_q[s] <= den_q[s-1];
        lo_q[s]  <= {lo_q[s-1][LW-2:0], 1'b0};
      end
      for (int s = 1; s <= QN; s++) begin
        ovf_q[s] <= ovf_q[s-1];
        quo_q[s] <= {quo_q[s-1][QN-2:0], ge[s-1]};
      end
    end
  end

  // Clamp to the cap
  assign quo_o = (ovf_q[QN] || (quo_q[QN] > wtsp_pkg::DivCap))
               ? wtsp_pkg::DivCap : quo_q[QN];

endmodule

### hdl/world_to_screen_projection.sv
// World-to-screen perspective projection.
// Input channel: in_valid_i / in_ready_o carry one world point (signed Q24.8
// per axis). Output channel: out_valid_o / out_ready_i carry the screen point
// (signed Q20.12, saturated) with the in_front and div_zero flags.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i;
// write only while no request is in flight.
// The request passes 119 register stages, the first loaded at the accepting
// edge: four for offset, view-row products, sums and magnitudes, 56 for the
// bit-per-stage x/z and y/z quotient pipelines, 56 for the quotients by the
// projection scales, then one for 1 +- t and two for the center product
// and saturation.
// Throughput: one point per cycle while the output is not stalled; every stage holds a new request.
// Stall: while a result waits at the output, the whole pipeline holds and
// in_ready_o drops; nothing is lost or repeated.
// Reset: the configuration registers read as zero and the pipeline empties.
module world_to_screen_projection (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wtsp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [wtsp_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [wtsp_pkg::CoordW-1:0] world_x_i,
  input  logic signed [wtsp_pkg::CoordW-1:0] world_y_i,
  input  logic signed [wtsp_pkg::CoordW-1:0] world_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [wtsp_pkg::OutW-1:0]   screen_x_o,
  output logic signed [wtsp_pkg::OutW-1:0]   screen_y_o,
  output logic                               in_front_o,
  output logic                               div_zero_o
);

  // Configuration registers
  logic [wtsp_pkg::CoordW-1:0]     cam_pos_q [3];
  logic [wtsp_pkg::CfgW-1:0]       view_row_q [3];
  logic [2*wtsp_pkg::ScaleW-1:0]   proj_scales_q;
  logic [2*wtsp_pkg::CtrW-1:0]     screen_center_q;

  logic [wtsp_pkg::ScaleW-1:0] px, py;
  logic [wtsp_pkg::CtrW-1:0]   cx, cy;

  assign px = proj_scales_q[wtsp_pkg::ScaleW-1:0];
  assign py = proj_scales_q[2*wtsp_pkg::ScaleW-1:wtsp_pkg::ScaleW];
  assign cx = screen_center_q[wtsp_pkg::CtrW-1:0];
  assign cy = screen_center_q[2*wtsp_pkg::CtrW-1:wtsp_pkg::CtrW];

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_pos_q[0]    <= '0;
      cam_pos_q[1]    <= '0;
      cam_pos_q[2]    <= '0;
      view_row_q[0]   <= '0;
      view_row_q[1]   <= '0;
      view_row_q[2]   <= '0;
      proj_scales_q   <= '0;
      screen_center_q <= '0;
    end else if (cfg_we_i) begin
      unique case (wtsp_pkg::cfg_reg_e'(cfg_idx_i))
        wtsp_pkg::RegCamPosX:    cam_pos_q[0]  <= cfg_data_i[wtsp_pkg::CoordW-1:0];
        wtsp_pkg::RegCamPosY:    cam_pos_q[1]  <= cfg_data_i[wtsp_pkg::CoordW-1:0];
        wtsp_pkg::RegCamPosZ:    cam_pos_q[2]  <= cfg_data_i[wtsp_pkg::CoordW-1:0];
        wtsp_pkg::RegRowAside:   view_row_q[0] <= cfg_data_i;
        wtsp_pkg::RegRowUp:      view_row_q[1] <= cfg_data_i;
        wtsp_pkg::RegRowForward: view_row_q[2] <= cfg_data_i;
        wtsp_pkg::RegProjScales: proj_scales_q <= cfg_data_i[2*wtsp_pkg::ScaleW-1:0];
        wtsp_pkg::RegScreenCtr:  screen_center_q <= cfg_data_i[2*wtsp_pkg::CtrW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves whenever the output slot frees
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Valid bits for every stage
  logic v1_q, v2_q, v3_q, v4_q, vf_q, vm_q, vo_q;
  logic vd_q [wtsp_pkg::DivPipeLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vf_q <= 1'b0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
      for (int i = 0; i < wtsp_pkg::DivPipeLat; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      vd_q[0] <= v4_q;
      for (int i = 1; i < wtsp_pkg::DivPipeLat; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
      vf_q <= vd_q[wtsp_pkg::DivPipeLat-1];
      vm_q <= vf_q;
      vo_q <= vm_q;
    end
  end

  // Stage 1: offset from the camera
  function automatic logic signed [wtsp_pkg::RelW-1:0] RelW_sub(
    input logic signed [wtsp_pkg::CoordW-1:0] a,
    input logic [wtsp_pkg::CoordW-1:0]        b
  );
    logic signed [wtsp_pkg::RelW-1:0] ae, be;
    ae = {a[wtsp_pkg::CoordW-1], a};
    be = {b[wtsp_pkg::CoordW-1], b};
    return ae - be;
  endfunction

  logic signed [wtsp_pkg::CoordW-1:0] world [3];
  logic signed [wtsp_pkg::RelW-1:0]   rel_q [3];

  assign world[0] = world_x_i;
  assign world[1] = world_y_i;
  assign world[2] = world_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rel_q[k] <= RelW_sub(world[k], cam_pos_q[k]);
      end
    end
  end

  // Stage 2: nine view-row products, floored to Q.16
  logic signed [wtsp_pkg::ProdW-1:0] prod [3][3];
  logic signed [wtsp_pkg::TermW-1:0] term_q [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r][k] = rel_q[k] * $signed(view_row_q[r][k*wtsp_pkg::MatW +: wtsp_pkg::MatW]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          term_q[r][k] <= prod[r][k][wtsp_pkg::ProdW-1:wtsp_pkg::MatSh];
        end
      end
    end
  end

  // Stage 3: camera-space x, y, z
  logic signed [wtsp_pkg::SumW-1:0] cam_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        cam_q[r] <= wtsp_pkg::SumW'(term_q[r][0]) + wtsp_pkg::SumW'(term_q[r][1])
                  + wtsp_pkg::SumW'(term_q[r][2]);
      end
    end
  end

  // Stage 4: magnitudes, signs and flags
  logic [wtsp_pkg::MagW-1:0] ax4_q, ay4_q, az4_q;
  logic [wtsp_pkg::SumW-1:0] negc [3];
  wtsp_pkg::side_t           side4_q;
  wtsp_pkg::side_t           side_d_q [wtsp_pkg::DivPipeLat];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      negc[r] = cam_q[r][wtsp_pkg::SumW-1] ? -cam_q[r] : cam_q[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax4_q <= negc[0][wtsp_pkg::MagW-1:0];
      ay4_q <= negc[1][wtsp_pkg::MagW-1:0];
      az4_q <= negc[2][wtsp_pkg::MagW-1:0];
      side4_q.neg_x    <= cam_q[0][wtsp_pkg::SumW-1] ^ cam_q[2][wtsp_pkg::SumW-1];
      side4_q.neg_y    <= cam_q[1][wtsp_pkg::SumW-1] ^ cam_q[2][wtsp_pkg::SumW-1];
      side4_q.in_front <= (cam_q[2] >= wtsp_pkg::NearZ);
      side4_q.div_zero <= (cam_q[2] == '0) || (px == '0) || (py == '0);
    end
  end

  // Quotient pipelines: r = |x| / |z| first, then t = r / scale
  logic [wtsp_pkg::DivQW-1:0] rx, ry, tqx, tqy;
  logic [wtsp_pkg::QW-1:0]    tx, ty;

  wtsp_div u_div_rx (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (wtsp_pkg::DivNW'(ax4_q)),
    .den_i (az4_q),
    .quo_o (rx)
  );

  wtsp_div u_div_ry (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (wtsp_pkg::DivNW'(ay4_q)),
    .den_i (az4_q),
    .quo_o (ry)
  );

  wtsp_div u_div_tx (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (rx),
    .den_i (wtsp_pkg::DivDW'(px)),
    .quo_o (tqx)
  );

  wtsp_div u_div_ty (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ry),
    .den_i (wtsp_pkg::DivDW'(py)),
    .quo_o (tqy)
  );

  // Drop the extra fraction bits of the scale quotient
  assign tx = tqx[wtsp_pkg::DivQW-1:wtsp_pkg::TSh];
  assign ty = tqy[wtsp_pkg::DivQW-1:wtsp_pkg::TSh];

  // Delay the flags alongside both quotient pipelines
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_d_q[0] <= side4_q;
      for (int i = 1; i < wtsp_pkg::DivPipeLat; i++) begin
        side_d_q[i] <= side_d_q[i-1];
      end
    end
  end

  // Stage F: form 1 + t and 1 - t in Q.24
  wtsp_pkg::side_t               sidef_q, sidem_q;
  wtsp_pkg::side_t               side_last;
  logic signed [wtsp_pkg::FW-1:0] tsx, tsy, fx_q, fy_q;

  assign side_last = side_d_q[wtsp_pkg::DivPipeLat-1];
  assign tsx = side_last.neg_x ? -$signed({1'b0, tx}) : $signed({1'b0, tx});
  assign tsy = side_last.neg_y ? -$signed({1'b0, ty}) : $signed({1'b0, ty});

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q    <= wtsp_pkg::OneQ24 + tsx;
      fy_q    <= wtsp_pkg::OneQ24 - tsy;
      sidef_q <= side_last;
    end
  end

  // Stage M: center times factor, low and high halves
  logic [wtsp_pkg::PLoW-1:0]        plo_x_q, plo_y_q;
  logic signed [wtsp_pkg::PHiW-1:0] phi_x_q, phi_y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_x_q <= cx * fx_q[wtsp_pkg::FLoW-1:0];
      plo_y_q <= cy * fy_q[wtsp_pkg::FLoW-1:0];
      phi_x_q <= $signed({1'b0, cx}) * $signed(fx_q[wtsp_pkg::FW-1:wtsp_pkg::FLoW]);
      phi_y_q <= $signed({1'b0, cy}) * $signed(fy_q[wtsp_pkg::FW-1:wtsp_pkg::FLoW]);
      sidem_q <= sidef_q;
    end
  end

  // Stage P: floor to Q20.12 and saturate
  function automatic logic signed [wtsp_pkg::OutW-1:0] sat_out(
    input logic signed [wtsp_pkg::PHiW-1:0] hi,
    input logic [wtsp_pkg::PLoW-1:0]        lo
  );
    logic signed [wtsp_pkg::FullW-1:0]        full;
    logic signed [wtsp_pkg::FullW-wtsp_pkg::OutSh-1:0]  p;
    full = $signed({hi, {wtsp_pkg::FLoW{1'b0}}})
         + $signed({{(wtsp_pkg::FullW - wtsp_pkg::PLoW){1'b0}}, lo});
    p = full[wtsp_pkg::FullW-1:wtsp_pkg::OutSh];
    if (p > $signed({{(wtsp_pkg::FullW - wtsp_pkg::OutSh - wtsp_pkg::OutW + 1){1'b0}},
                     {(wtsp_pkg::OutW - 1){1'b1}}})) begin
      return {1'b0, {(wtsp_pkg::OutW - 1){1'b1}}};
    end else if (p < $signed({{(wtsp_pkg::FullW - wtsp_pkg::OutSh - wtsp_pkg::OutW + 1){1'b1}},
                              {(wtsp_pkg::OutW - 1){1'b0}}})) begin
      return {1'b1, {(wtsp_pkg::OutW - 1){1'b0}}};
    end
    return p[wtsp_pkg::OutW-1:0];
  endfunction

  logic signed [wtsp_pkg::OutW-1:0] sx_q, sy_q;
  logic                             front_q, dz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q    <= sat_out(phi_x_q, plo_x_q);
      sy_q    <= sat_out(phi_y_q, plo_y_q);
      front_q <= sidem_q.in_front;
      dz_q    <= sidem_q.div_zero;
    end
  end

  assign out_valid_o = vo_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign in_front_o  = front_q;
  assign div_zero_o  = dz_q;

`ifndef ASSERT_OFF
  // A point in front with nonzero scales never flags a zero divide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_front_o && (px != '0) && (py != '0) |-> !div_zero_o)
    else $error("div_zero set for a point in front of the camera");

  // A zero horizontal center projects to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cx == '0) |-> (screen_x_o == '0))
    else $error("screen_x nonzero with zero center");

  // The first stage fills only from an offered request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v1_q) |-> $past(in_valid_i))
    else $error("stage one filled without a request");
`endif

endmodule
